@@ src/gga_pkg.sv @@
package gga_pkg;

  // Parse phases: seven header characters, then the record fields
  typedef enum logic [3:0] {
    PH_HDR0    = 4'd0,
    PH_HDR1    = 4'd1,
    PH_HDR2    = 4'd2,
    PH_HDR3    = 4'd3,
    PH_HDR4    = 4'd4,
    PH_HDR5    = 4'd5,
    PH_HDR6    = 4'd6,
    PH_TIME    = 4'd7,
    PH_LAT     = 4'd8,
    PH_LAT_DIR = 4'd9,
    PH_LON     = 4'd10,
    PH_LON_DIR = 4'd11,
    PH_POS     = 4'd12,
    PH_SATS    = 4'd13
  } phase_t;

  localparam logic [7:0] COMMA = 8'h2C;

  // "$GPGGA,"
  localparam logic [6:0][7:0] HEADER = {8'h2C, 8'h41, 8'h47, 8'h47, 8'h50, 8'h47, 8'h24};

  // Text slots in the capture store
  localparam logic [1:0] SLOT_TIME = 2'd0;
  localparam logic [1:0] SLOT_LAT  = 2'd1;
  localparam logic [1:0] SLOT_LON  = 2'd2;
  localparam logic [1:0] SLOT_SATS = 2'd3;

  // Result field identifiers
  localparam logic [2:0] FID_TIME    = 3'd0;
  localparam logic [2:0] FID_LAT     = 3'd1;
  localparam logic [2:0] FID_LAT_DIR = 3'd2;
  localparam logic [2:0] FID_LON     = 3'd3;
  localparam logic [2:0] FID_LON_DIR = 3'd4;
  localparam logic [2:0] FID_SATS    = 3'd5;

  localparam logic [2:0] NUM_RESULTS = 3'd6;

  // Captured record as seen by the result sequencer
  typedef struct packed {
    logic [3:0][15:0][7:0] text;
    logic [3:0][4:0]       lengths;
    logic [3:0]            overflow;
    logic [1:0][7:0]       dirs;
  } rec_t;

endpackage

@@ src/gga_byte_if.sv @@
interface gga_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ src/gga_field_if.sv @@
interface gga_field_if;
  logic        valid;
  logic        ready;
  logic [2:0]  field_id;
  logic [4:0]  text_length;
  logic [63:0] text_low;
  logic [63:0] text_high;
  logic        truncated;
  logic        last;

  modport source (output valid, output field_id, output text_length, output text_low,
                  output text_high, output truncated, output last, input ready);
  modport sink   (input valid, input field_id, input text_length, input text_low,
                  input text_high, input truncated, input last, output ready);
endinterface

@@ src/gga_capture.sv @@
module gga_capture #(
  parameter int FIELD_CHARS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    rx_byte,
  output logic          done,
  output gga_pkg::rec_t rec
);

  gga_pkg::phase_t phase, phase_next;
  logic [4:0]      char_index;
  logic [3:0][15:0][7:0] text;
  logic [3:0][4:0] lengths;
  logic [3:0]      overflow;
  logic [1:0][7:0] dirs;

  logic       is_comma;
  logic       hdr_match;
  logic       hdr_done;
  logic       text_phase;
  logic [1:0] slot;
  logic       room;
  logic       store_en;
  logic       ovf_set;
  logic       len_wr;
  logic [1:0] dir_wr;
  logic       rec_done;

  assign is_comma = (rx_byte == gga_pkg::COMMA);
  assign room     = (char_index < 5'(FIELD_CHARS));

  // Header character expected in the current phase
  always_comb begin
    case (phase)
      gga_pkg::PH_HDR0, gga_pkg::PH_HDR1, gga_pkg::PH_HDR2, gga_pkg::PH_HDR3,
      gga_pkg::PH_HDR4, gga_pkg::PH_HDR5, gga_pkg::PH_HDR6:
        hdr_match = (rx_byte == gga_pkg::HEADER[phase[2:0]]);
      default: hdr_match = (rx_byte == gga_pkg::HEADER[0]);
    endcase
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (take) begin
      case (phase)
        gga_pkg::PH_HDR0, gga_pkg::PH_HDR1, gga_pkg::PH_HDR2, gga_pkg::PH_HDR3,
        gga_pkg::PH_HDR4, gga_pkg::PH_HDR5, gga_pkg::PH_HDR6:
          phase_next = hdr_match ? gga_pkg::phase_t'(phase + 4'd1) : gga_pkg::PH_HDR0;
        gga_pkg::PH_TIME, gga_pkg::PH_LAT, gga_pkg::PH_LAT_DIR, gga_pkg::PH_LON,
        gga_pkg::PH_LON_DIR, gga_pkg::PH_POS:
          if (is_comma) phase_next = gga_pkg::phase_t'(phase + 4'd1);
        gga_pkg::PH_SATS:
          if (is_comma) phase_next = gga_pkg::PH_HDR0;
        default:
          phase_next = hdr_match ? gga_pkg::PH_HDR1 : gga_pkg::PH_HDR0;
      endcase
    end
  end

  // Write strobes for the capture store
  always_comb begin
    hdr_done   = 1'b0;
    text_phase = 1'b0;
    slot       = gga_pkg::SLOT_TIME;
    dir_wr     = 2'b00;
    rec_done   = 1'b0;
    case (phase)
      gga_pkg::PH_HDR6:    hdr_done = take && hdr_match;
      gga_pkg::PH_TIME:    text_phase = 1'b1;
      gga_pkg::PH_LAT: begin
        text_phase = 1'b1;
        slot       = gga_pkg::SLOT_LAT;
      end
      gga_pkg::PH_LAT_DIR: dir_wr[0] = take && !is_comma;
      gga_pkg::PH_LON: begin
        text_phase = 1'b1;
        slot       = gga_pkg::SLOT_LON;
      end
      gga_pkg::PH_LON_DIR: dir_wr[1] = take && !is_comma;
      gga_pkg::PH_SATS: begin
        text_phase = 1'b1;
        slot       = gga_pkg::SLOT_SATS;
        rec_done   = take && is_comma;
      end
      default: ;
    endcase
    store_en = take && text_phase && !is_comma && room;
    ovf_set  = take && text_phase && !is_comma && !room;
    len_wr   = take && text_phase && is_comma;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= gga_pkg::PH_HDR0;
      char_index <= '0;
      lengths    <= '0;
      overflow   <= '0;
      dirs       <= '0;
      done       <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= rec_done;
      if (hdr_done || len_wr) char_index <= '0;
      else if (store_en)      char_index <= char_index + 5'd1;
      if (len_wr) lengths[slot] <= char_index;
      if (hdr_done) begin
        overflow <= '0;
        dirs     <= '0;
      end else begin
        if (ovf_set)   overflow[slot] <= 1'b1;
        if (dir_wr[0]) dirs[0] <= rx_byte;
        if (dir_wr[1]) dirs[1] <= rx_byte;
      end
    end
  end

  // Text store: bytes past the field length are masked on the way out
  always_ff @(posedge clk) begin
    if (store_en) text[slot][char_index[3:0]] <= rx_byte;
  end

  assign rec.text     = text;
  assign rec.lengths  = lengths;
  assign rec.overflow = overflow;
  assign rec.dirs     = dirs;

endmodule

@@ src/gga_emit.sv @@
module gga_emit (
  input  logic          clk,
  input  logic          rst,
  input  logic          done,
  input  gga_pkg::rec_t rec,
  output logic          busy,
  gga_field_if.source   fld
);

  logic [2:0]  idx;
  logic [2:0]  sel;
  logic        valid;
  logic [2:0]  out_id;
  logic [4:0]  out_len;
  logic [63:0] out_low;
  logic [63:0] out_high;
  logic        out_trunc;
  logic        out_last;

  logic [2:0]   res_id;
  logic [4:0]   res_len;
  logic [127:0] res_text;
  logic         res_trunc;

  // Zero every byte at or beyond the captured length
  function automatic logic [127:0] mask_text(input logic [15:0][7:0] t, input logic [4:0] len);
    logic [127:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < len) r[8*i +: 8] = t[i];
    end
    return r;
  endfunction

  assign sel = done ? 3'd0 : idx;

  // Select result for the current position of the record
  always_comb begin
    res_id    = sel;
    res_len   = '0;
    res_text  = '0;
    res_trunc = 1'b0;
    case (sel)
      gga_pkg::FID_TIME: begin
        res_len   = rec.lengths[gga_pkg::SLOT_TIME];
        res_text  = mask_text(rec.text[gga_pkg::SLOT_TIME], res_len);
        res_trunc = rec.overflow[gga_pkg::SLOT_TIME];
      end
      gga_pkg::FID_LAT: begin
        res_len   = rec.lengths[gga_pkg::SLOT_LAT];
        res_text  = mask_text(rec.text[gga_pkg::SLOT_LAT], res_len);
        res_trunc = rec.overflow[gga_pkg::SLOT_LAT];
      end
      gga_pkg::FID_LAT_DIR: begin
        res_len  = {4'd0, rec.dirs[0] != 8'd0};
        res_text = {120'd0, rec.dirs[0]};
      end
      gga_pkg::FID_LON: begin
        res_len   = rec.lengths[gga_pkg::SLOT_LON];
        res_text  = mask_text(rec.text[gga_pkg::SLOT_LON], res_len);
        res_trunc = rec.overflow[gga_pkg::SLOT_LON];
      end
      gga_pkg::FID_LON_DIR: begin
        res_len  = {4'd0, rec.dirs[1] != 8'd0};
        res_text = {120'd0, rec.dirs[1]};
      end
      gga_pkg::FID_SATS: begin
        res_len   = rec.lengths[gga_pkg::SLOT_SATS];
        res_text  = mask_text(rec.text[gga_pkg::SLOT_SATS], res_len);
        res_trunc = rec.overflow[gga_pkg::SLOT_SATS];
      end
      default: ;
    endcase
  end

  // Sequence control: load first result on record end, advance on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (done) begin
      valid <= 1'b1;
      idx   <= 3'd1;
    end else if (valid && fld.ready) begin
      if (idx == gga_pkg::NUM_RESULTS) valid <= 1'b0;
      else                             idx   <= idx + 3'd1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (done || (valid && fld.ready && idx != gga_pkg::NUM_RESULTS)) begin
      out_id    <= res_id;
      out_len   <= res_len;
      out_low   <= res_text[63:0];
      out_high  <= res_text[127:64];
      out_trunc <= res_trunc;
      out_last  <= (res_id == gga_pkg::FID_SATS);
    end
  end

  assign busy            = done || valid;
  assign fld.valid       = valid;
  assign fld.field_id    = out_id;
  assign fld.text_length = out_len;
  assign fld.text_low    = out_low;
  assign fld.text_high   = out_high;
  assign fld.truncated   = out_trunc;
  assign fld.last        = out_last;

endmodule

@@ src/nmea_gga_field_extractor_top.sv @@
// GGA sentence field extractor.
// rx carries one stream byte per transfer. The block looks for "$GPGGA," and
// then captures time, latitude, latitude direction, longitude, longitude
// direction and satellite count; the position-type field is skipped.
// fld carries six results per record, in that order, the last one marked;
// each holds up to 16 characters packed low byte first, with a length and a
// truncation flag for text fields longer than FIELD_CHARS.
// Throughput: one byte per cycle while no results are pending.
// The first result goes valid once the comma that closes the satellite field
// has been transferred and done has been registered; the rest follow one
// per cycle while fld.ready is high.
// rx.ready is low from the cycle after that comma until the sixth result is
// transferred, since the results are read from the capture store. A stalled
// receiver simply holds the current result and the input.
// Reset (rst, synchronous) returns the parser to header search and drops
// any pending results.
module nmea_gga_field_extractor_top #(
  parameter int FIELD_CHARS = 16
) (
  input  logic        clk,
  input  logic        rst,
  gga_byte_if.sink    rx,
  gga_field_if.source fld
);

  logic          take;
  logic          done;
  logic          busy;
  gga_pkg::rec_t rec;

  // Hold off input while a record is being delivered
  assign rx.ready = !busy;
  assign take     = rx.valid && !busy;

  gga_capture #(
    .FIELD_CHARS (FIELD_CHARS)
  ) u_capture (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx.rx_byte),
    .done    (done),
    .rec     (rec)
  );

  gga_emit u_emit (
    .clk  (clk),
    .rst  (rst),
    .done (done),
    .rec  (rec),
    .busy (busy),
    .fld  (fld)
  );

endmodule
